// ----- src/ssto_pkg.sv -----
`default_nettype none

package ssto_pkg;

    localparam int NUM_W    = 50;
    localparam int DEN_W    = 32;
    localparam int Q_W      = 31;
    localparam int DIV_LAT  = Q_W + 1;
    localparam int PIPE_LAT = DIV_LAT + 4;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X      = 3'd0,
        CFG_CENTER_Y      = 3'd1,
        CFG_BASELINE      = 3'd2,
        CFG_FOCAL_LENGTH  = 3'd3,
        CFG_PIXELS_PER_MM = 3'd4,
        CFG_Z_LIMIT       = 3'd5
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] RST_CENTER_X      = 16'd0;
    localparam logic [CFG_W-1:0] RST_CENTER_Y      = 16'd0;
    localparam logic [CFG_W-1:0] RST_BASELINE      = 16'd1920;
    localparam logic [CFG_W-1:0] RST_FOCAL_LENGTH  = 16'd3891;
    localparam logic [CFG_W-1:0] RST_PIXELS_PER_MM = 16'd10667;
    localparam logic [CFG_W-1:0] RST_Z_LIMIT       = 16'd500;

    typedef struct packed {
        logic dz;
        logic negx;
        logic negy;
        logic negz;
        logic keep;
    } t_side;

endpackage

`default_nettype wire

// ----- src/ssto_div.sv -----
`default_nettype none

module ssto_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire logic [ssto_pkg::NUM_W-1:0] i_num,
    input  wire logic [ssto_pkg::DEN_W-1:0] i_den,
    output logic                            o_valid,
    output logic [ssto_pkg::Q_W-1:0]        o_quo,
    output logic                            o_ovf
);

    logic                        r_v   [0:ssto_pkg::Q_W];
    logic [ssto_pkg::DEN_W-1:0]  r_rem [0:ssto_pkg::Q_W];
    logic [ssto_pkg::DEN_W-1:0]  r_den [0:ssto_pkg::Q_W];
    logic [ssto_pkg::Q_W-1:0]    r_num [0:ssto_pkg::Q_W];
    logic [ssto_pkg::Q_W-1:0]    r_quo [0:ssto_pkg::Q_W];
    logic                        r_ovf [0:ssto_pkg::Q_W];

    logic [ssto_pkg::DEN_W-1:0]  n_hi;

    assign n_hi = ssto_pkg::DEN_W'(i_num[ssto_pkg::NUM_W-1:ssto_pkg::Q_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
        r_rem[0] <= n_hi;
        r_den[0] <= i_den;
        r_num[0] <= i_num[ssto_pkg::Q_W-1:0];
        r_quo[0] <= '0;
        r_ovf[0] <= (n_hi >= i_den);
    end

    for (genvar k = 1; k <= ssto_pkg::Q_W; k++) begin : g_step
        logic [ssto_pkg::DEN_W:0]   n_t;
        logic                       n_ge;
        logic [ssto_pkg::DEN_W:0]   n_diff;

        always_comb begin
            n_t    = {r_rem[k-1], r_num[k-1][ssto_pkg::Q_W-1]};
            n_ge   = (n_t >= {1'b0, r_den[k-1]});
            n_diff = n_ge ? (n_t - {1'b0, r_den[k-1]}) : n_t;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= r_v[k-1];
            end
            r_rem[k] <= n_diff[ssto_pkg::DEN_W-1:0];
            r_den[k] <= r_den[k-1];
            r_num[k] <= {r_num[k-1][ssto_pkg::Q_W-2:0], 1'b0};
            r_quo[k] <= {r_quo[k-1][ssto_pkg::Q_W-2:0], n_ge};
            r_ovf[k] <= r_ovf[k-1];
        end
    end

    assign o_valid = r_v[ssto_pkg::Q_W];
    assign o_quo   = r_quo[ssto_pkg::Q_W];
    assign o_ovf   = r_ovf[ssto_pkg::Q_W];

`ifndef SYNTHESIS
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[ssto_pkg::Q_W] && !r_ovf[ssto_pkg::Q_W])
            |-> (r_rem[ssto_pkg::Q_W] < r_den[ssto_pkg::Q_W]))
        else $error("remainder not below divisor");

    a_valid_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[0] |-> ##(ssto_pkg::Q_W) o_valid)
        else $error("valid lost in divider");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[0] |-> ##(ssto_pkg::Q_W) !o_valid)
        else $error("spurious valid from divider");
`endif

endmodule

`default_nettype wire

// ----- src/standard_stereo_triangulation.sv -----
`default_nettype none

// Channel   Direction  Handshake                    Payload
// command   in         i_start, o_busy              i_left_x, i_left_y, i_right_x
// result    out        o_valid (one-cycle strobe)   o_point_x, o_point_y, o_point_z, o_kept
// config    in         i_cfg_valid, o_cfg_ready     i_cfg_index, i_cfg_data
//
// One transaction per cycle; a command passes stages 1 to 3, the input register and
// 31-stage restoring divider of ssto_div, and an output register on its way to a result.
// Reset (i_rst_n low, synchronous) loads register defaults and drops work in flight.
// o_busy stays low: the pipeline never stalls, as results cannot be held off.

module standard_stereo_triangulation (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    output logic                                o_busy,
    input  wire logic [15:0]                    i_left_x,
    input  wire logic [15:0]                    i_left_y,
    input  wire logic [15:0]                    i_right_x,
    output logic                                o_valid,
    output logic signed [31:0]                  o_point_x,
    output logic signed [31:0]                  o_point_y,
    output logic signed [31:0]                  o_point_z,
    output logic                                o_kept,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [ssto_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [ssto_pkg::CFG_W-1:0]     i_cfg_data
);

    logic [15:0] r_center_x, r_center_y, r_baseline, r_focal_length;
    logic [15:0] r_pixels_per_mm, r_z_limit;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x      <= ssto_pkg::RST_CENTER_X;
            r_center_y      <= ssto_pkg::RST_CENTER_Y;
            r_baseline      <= ssto_pkg::RST_BASELINE;
            r_focal_length  <= ssto_pkg::RST_FOCAL_LENGTH;
            r_pixels_per_mm <= ssto_pkg::RST_PIXELS_PER_MM;
            r_z_limit       <= ssto_pkg::RST_Z_LIMIT;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ssto_pkg::CFG_CENTER_X:      r_center_x      <= i_cfg_data;
                ssto_pkg::CFG_CENTER_Y:      r_center_y      <= i_cfg_data;
                ssto_pkg::CFG_BASELINE:      r_baseline      <= i_cfg_data;
                ssto_pkg::CFG_FOCAL_LENGTH:  r_focal_length  <= i_cfg_data;
                ssto_pkg::CFG_PIXELS_PER_MM: r_pixels_per_mm <= i_cfg_data;
                ssto_pkg::CFG_Z_LIMIT:       r_z_limit       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic signed [17:0] n_sx;
    logic signed [16:0] n_y1;
    logic signed [16:0] n_d;
    logic signed [17:0] n_sx_abs;
    logic signed [16:0] n_y1_abs;
    logic signed [16:0] n_d_abs;

    always_comb begin
        n_sx = $signed({2'b00, i_left_x}) + $signed({2'b00, i_right_x})
             - $signed({1'b0, r_center_x, 1'b0});
        n_y1 = $signed({1'b0, r_center_y}) - $signed({1'b0, i_left_y});
        n_d  = $signed({1'b0, i_left_x}) - $signed({1'b0, i_right_x});
        n_sx_abs = n_sx[17] ? -n_sx : n_sx;
        n_y1_abs = n_y1[16] ? -n_y1 : n_y1;
        n_d_abs  = n_d[16]  ? -n_d  : n_d;
    end

    // stage 1: centre and take magnitudes
    logic        r1_v, r1_dz, r1_dneg, r1_xpos, r1_yneg;
    logic [16:0] r1_sx;
    logic [15:0] r1_y1, r1_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= i_start && !o_busy;
        end
        r1_dz   <= (n_d == '0);
        r1_dneg <= n_d[16];
        r1_xpos <= !n_sx[17] && (n_sx != '0);
        r1_yneg <= n_y1[16];
        r1_sx   <= n_sx_abs[16:0];
        r1_y1   <= n_y1_abs[15:0];
        r1_d    <= n_d_abs[15:0];
    end

    // stage 2: first products
    logic        r2_v, r2_dz, r2_dneg, r2_negx, r2_negy;
    logic [31:0] r2_bf;
    logic [33:0] r2_nx, r2_ny;
    logic [20:0] r2_dx;
    logic [30:0] r2_dzd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
        r2_dz   <= r1_dz;
        r2_dneg <= r1_dneg;
        r2_negx <= r1_xpos ^ r1_dneg;
        r2_negy <= r1_yneg ^ r1_dneg;
        r2_bf   <= 32'(r_baseline) * 32'(r_focal_length);
        r2_nx   <= (34'(r_baseline) * 34'(r1_sx)) << 1;
        r2_ny   <= (34'(r_baseline) * 34'(r1_y1)) << 2;
        r2_dx   <= 21'(r1_d) * 21'd25;
        r2_dzd  <= 31'(r1_d) * 31'd25600;
    end

    // stage 3: depth numerator and limit
    logic        r3_v, r3_dz, r3_dneg, r3_negx, r3_negy;
    logic [47:0] r3_nz;
    logic [46:0] r3_lim;
    logic [33:0] r3_nx, r3_ny;
    logic [20:0] r3_dx;
    logic [30:0] r3_dzd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else begin
            r3_v <= r2_v;
        end
        r3_dz   <= r2_dz;
        r3_dneg <= r2_dneg;
        r3_negx <= r2_negx;
        r3_negy <= r2_negy;
        r3_nz   <= 48'(r2_bf) * 48'(r_pixels_per_mm);
        r3_lim  <= 47'(r_z_limit) * 47'(r2_dzd);
        r3_nx   <= r2_nx;
        r3_ny   <= r2_ny;
        r3_dx   <= r2_dx;
        r3_dzd  <= r2_dzd;
    end

    logic [ssto_pkg::NUM_W-1:0] n_num_x, n_num_y, n_num_z;
    logic [ssto_pkg::DEN_W-1:0] n_den_xy, n_den_z;
    ssto_pkg::t_side            n_side;

    always_comb begin
        n_num_x  = ssto_pkg::NUM_W'({r3_nx, 1'b0}) + ssto_pkg::NUM_W'(r3_dx);
        n_num_y  = ssto_pkg::NUM_W'({r3_ny, 1'b0}) + ssto_pkg::NUM_W'(r3_dx);
        n_num_z  = ssto_pkg::NUM_W'({r3_nz, 1'b0}) + ssto_pkg::NUM_W'(r3_dzd);
        n_den_xy = ssto_pkg::DEN_W'({r3_dx, 1'b0});
        n_den_z  = ssto_pkg::DEN_W'({r3_dzd, 1'b0});
        n_side.dz   = r3_dz;
        n_side.negx = r3_negx;
        n_side.negy = r3_negy;
        n_side.negz = r3_dneg;
        if (r3_dz) begin
            n_side.keep = 1'b0;
        end else if (r3_nz == '0) begin
            n_side.keep = 1'b1;
        end else if (r3_dneg) begin
            n_side.keep = 1'b0;
        end else begin
            n_side.keep = (r3_nz <= 48'(r3_lim));
        end
    end

    logic                     w_div_v, w_div_vy, w_div_vz;
    logic [ssto_pkg::Q_W-1:0] w_qx, w_qy, w_qz;
    logic                     w_ox, w_oy, w_oz;

    ssto_div u_div_x (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r3_v),
        .i_num(n_num_x), .i_den(n_den_xy),
        .o_valid(w_div_v), .o_quo(w_qx), .o_ovf(w_ox)
    );

    ssto_div u_div_y (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r3_v),
        .i_num(n_num_y), .i_den(n_den_xy),
        .o_valid(w_div_vy), .o_quo(w_qy), .o_ovf(w_oy)
    );

    ssto_div u_div_z (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r3_v),
        .i_num(n_num_z), .i_den(n_den_z),
        .o_valid(w_div_vz), .o_quo(w_qz), .o_ovf(w_oz)
    );

    ssto_pkg::t_side r_sb [0:ssto_pkg::DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        r_sb[0] <= n_side;
        for (int i = 1; i < ssto_pkg::DIV_LAT; i++) begin
            r_sb[i] <= r_sb[i-1];
        end
    end

    function automatic logic [31:0] sat_sign(input logic [ssto_pkg::Q_W-1:0] q,
                                             input logic ovf, input logic neg);
        logic [31:0] mag;
        mag = {1'b0, q};
        if (neg) begin
            sat_sign = ovf ? 32'h8000_0000 : -mag;
        end else begin
            sat_sign = ovf ? 32'h7FFF_FFFF : mag;
        end
    endfunction

    ssto_pkg::t_side w_side;
    assign w_side = r_sb[ssto_pkg::DIV_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_div_v;
        end
        o_point_x <= w_side.dz ? '0 : $signed(sat_sign(w_qx, w_ox, w_side.negx));
        o_point_y <= w_side.dz ? '0 : $signed(sat_sign(w_qy, w_oy, w_side.negy));
        o_point_z <= w_side.dz ? '0 : $signed(sat_sign(w_qz, w_oz, w_side.negz));
        o_kept    <= w_side.keep;
    end

`ifndef SYNTHESIS
    a_kept_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kept) |-> !o_point_z[31])
        else $error("kept point with negative depth");

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##(ssto_pkg::PIPE_LAT) o_valid)
        else $error("result missing after pipeline latency");

    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_v == w_div_vy) && (w_div_v == w_div_vz))
        else $error("dividers out of step");
`endif

endmodule

`default_nettype wire
